[rtl/mciir_pkg.sv]
package mciir_pkg;

  // Request codes carried by an input item
  typedef enum logic [1:0] {
    REQ_SAMPLE  = 2'd0,
    REQ_FF_COEF = 2'd1,
    REQ_FB_COEF = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_t;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FILTER_ORDER  = 1'b0,
    CFG_CHANNEL_COUNT = 1'b1
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Operand pair selected for one multiply-accumulate slot
  typedef enum logic [1:0] {
    MAC_X0,
    MAC_FF,
    MAC_FB
  } mac_sel_t;

  typedef struct packed {
    logic     vld;
    mac_sel_t sel;
  } mac_ctrl_t;

endpackage

[rtl/mciir_if.sv]
// Input item channel
interface mciir_in_if #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 48,
  parameter int IDX_BITS    = 6
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic [IDX_BITS-1:0]           coeff_index;
  logic signed [COEF_BITS-1:0]   coeff_value;

  modport source (output valid, req_type, sample_in, coeff_index, coeff_value, input ready);
  modport sink   (input valid, req_type, sample_in, coeff_index, coeff_value, output ready);
endinterface

// Result item channel
interface mciir_out_if #(
  parameter int SAMPLE_BITS = 24,
  parameter int CH_BITS     = 3
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic [CH_BITS-1:0]            channel_index;

  modport source (output valid, sample_out, channel_index, input ready);
  modport sink   (input valid, sample_out, channel_index, output ready);
endinterface

// Configuration write channel
interface mciir_cfg_if #(
  parameter int DATA_BITS = 6
);
  logic                                   valid;
  logic                                   ready;
  logic [mciir_pkg::CFG_IDX_BITS-1:0]     index;
  logic [DATA_BITS-1:0]                   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/mciir_tap_mem.sv]
module mciir_tap_mem #(
  parameter int DEPTH     = 33,
  parameter int AW        = 6,
  parameter int COEF_BITS = 48
) (
  input  logic                        clk,
  input  logic                        ff_we,
  input  logic                        fb_we,
  input  logic [AW-1:0]               waddr,
  input  logic [COEF_BITS-1:0]        wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic signed [COEF_BITS-1:0] ff_q,
  output logic signed [COEF_BITS-1:0] fb_q
);

  // Row holds the feed-forward tap in the upper half, feedback tap in the lower
  logic [2*COEF_BITS-1:0] mem [DEPTH];
  logic [2*COEF_BITS-1:0] q_r;

  // Write port with per-half enables
  always_ff @(posedge clk) begin
    if (ff_we) begin
      mem[waddr][2*COEF_BITS-1:COEF_BITS] <= wdata;
    end
    if (fb_we) begin
      mem[waddr][COEF_BITS-1:0] <= wdata;
    end
  end

  // Registered read; holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      q_r <= mem[raddr];
    end
  end

  assign ff_q = q_r[2*COEF_BITS-1:COEF_BITS];
  assign fb_q = q_r[COEF_BITS-1:0];

endmodule

[rtl/mciir_hist_mem.sv]
module mciir_hist_mem #(
  parameter int DEPTH = 264,
  parameter int AW    = 9,
  parameter int WIDTH = 48
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  // One row per channel and ring slot: {input sample, output sample}
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] q_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      q_r <= mem[raddr];
    end
  end

  assign rdata = q_r;

endmodule

[rtl/mciir_mac.sv]
module mciir_mac #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 48,
  parameter int MAX_ORDER   = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mciir_pkg::mac_ctrl_t          iss,
  input  logic signed [SAMPLE_BITS-1:0] x0,
  input  logic signed [SAMPLE_BITS-1:0] ih,
  input  logic signed [SAMPLE_BITS-1:0] oh,
  input  logic signed [COEF_BITS-1:0]   ff,
  input  logic signed [COEF_BITS-1:0]   fb,
  output logic                          busy,
  output logic signed [SAMPLE_BITS-1:0] y
);
  import mciir_pkg::*;

  localparam int CL    = COEF_BITS / 2;
  localparam int CH    = COEF_BITS - CL;
  localparam int PLW   = CL + 1 + SAMPLE_BITS;
  localparam int PHW   = CH + SAMPLE_BITS;
  localparam int ACC_W = SAMPLE_BITS + COEF_BITS + $clog2(2 * MAX_ORDER + 1) + 1;
  localparam int FRAC  = COEF_BITS - 8;

  mac_ctrl_t                     m_ctrl_r, p_ctrl_r, s_ctrl_r;
  logic signed [COEF_BITS-1:0]   coef;
  logic signed [SAMPLE_BITS-1:0] samp;
  logic signed [CL:0]            coef_lo;
  logic signed [CH-1:0]          coef_hi;
  logic signed [PLW-1:0]         pl_nxt, pl_r;
  logic signed [PHW-1:0]         ph_nxt, ph_r;
  logic signed [ACC_W-1:0]       prod_nxt, prod_r, acc_nxt, acc_r, rnd, shr;
  logic                          in_range;
  logic signed [SAMPLE_BITS-1:0] y_nxt, y_r;

  // Slot tags follow the data through the pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_ctrl_r <= '0;
      p_ctrl_r <= '0;
      s_ctrl_r <= '0;
    end else begin
      m_ctrl_r <= iss;
      p_ctrl_r <= m_ctrl_r;
      s_ctrl_r <= p_ctrl_r;
    end
  end

  assign busy = m_ctrl_r.vld | p_ctrl_r.vld | s_ctrl_r.vld;

  // Operand select against the memory read data
  always_comb begin
    unique case (m_ctrl_r.sel)
      MAC_X0: begin
        coef = ff;
        samp = x0;
      end
      MAC_FF: begin
        coef = ff;
        samp = ih;
      end
      MAC_FB: begin
        coef = fb;
        samp = oh;
      end
      default: begin
        coef = ff;
        samp = x0;
      end
    endcase
  end

  // Coefficient split in two halves, one partial product each
  assign coef_lo = $signed({1'b0, coef[CL-1:0]});
  assign coef_hi = coef[COEF_BITS-1:CL];
  assign pl_nxt  = coef_lo * samp;
  assign ph_nxt  = coef_hi * samp;

  // Partial products recombined, then accumulated
  assign prod_nxt = ({{(ACC_W-PHW){ph_r[PHW-1]}}, ph_r} << CL)
                  + {{(ACC_W-PLW){pl_r[PLW-1]}}, pl_r};
  assign acc_nxt  = (s_ctrl_r.sel == MAC_X0) ? prod_r : acc_r + prod_r;

  always_ff @(posedge clk) begin
    pl_r   <= pl_nxt;
    ph_r   <= ph_nxt;
    prod_r <= prod_nxt;
    if (s_ctrl_r.vld) begin
      acc_r <= acc_nxt;
    end
    y_r <= y_nxt;
  end

  // Round half up to the sample format and saturate
  assign rnd      = acc_r + (ACC_W'(1) << (FRAC - 1));
  assign shr      = rnd >>> FRAC;
  assign in_range = (&shr[ACC_W-1:SAMPLE_BITS-1]) | ~(|shr[ACC_W-1:SAMPLE_BITS-1]);
  assign y_nxt    = in_range ? shr[SAMPLE_BITS-1:0]
                  : (shr[ACC_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                  : {1'b0, {(SAMPLE_BITS-1){1'b1}}});

  assign y = y_r;

endmodule

[rtl/multichannel_iir_filter.sv]
// Direct form I IIR filter for up to CHANNELS interleaved channels.
// in_ch carries request items: a sample, a feed-forward or feedback tap
// write, or a history clear. Samples are assigned to channels round robin;
// each sample item yields one result item on out_ch with the filtered,
// rounded and saturated sample and its channel. Other items yield none.
// cfg_ch writes filter_order (index 0) and channel_count (index 1); it is
// always ready and should be written only while no sample is in flight.
// A sample item occupies the block until its write-back. It is computed by
// one shared multiply-accumulate that walks 2*order + 1 products, one per
// cycle, reading taps and history from synchronous memories that have a
// registered read. The result lands in an output register. A clear item, and
// reset, start a clearing pass over the CHANNELS*(MAX_ORDER+1) rows (264 by
// default) of the history memory during which in_ch is not ready; the pass
// after reset also zeroes taps. Reset restores order 4 and one channel. When
// out_ch stalls, the result waits in the output register; the next sample
// item is still accepted and computed, and only its write-back waits until
// the register is free.
module multichannel_iir_filter #(
  parameter int MAX_ORDER   = 32,
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 48
) (
  input  logic         clk,
  input  logic         rst_n,
  mciir_in_if.sink     in_ch,
  mciir_out_if.source  out_ch,
  mciir_cfg_if.sink    cfg_ch
);
  import mciir_pkg::*;

  localparam int RING       = MAX_ORDER + 1;
  localparam int IW         = $clog2(RING);
  localparam int CNTW       = $clog2(CHANNELS + 1);
  localparam int CHW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HIST_DEPTH = CHANNELS * RING;
  localparam int AW         = $clog2(HIST_DEPTH);
  localparam int HIST_W     = 2 * SAMPLE_BITS;

  state_t                        state_r, state_nxt;
  logic [IW-1:0]                 filter_order_r;
  logic [CNTW-1:0]               channel_count_r;
  logic [IW-1:0]                 hist_pos_r [CHANNELS];
  logic [CHW-1:0]                cur_ch_r;
  logic [AW-1:0]                 clr_cnt_r;
  logic                          clr_taps_r;
  logic signed [SAMPLE_BITS-1:0] x0_r;
  logic [CHW-1:0]                ch_r;
  logic [IW-1:0]                 ord_r, pos_r, i_r, j_r;
  logic                          phase_r;
  logic [AW-1:0]                 base_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic [CHW-1:0]                out_chan_r;

  logic                          in_acc, cfg_acc, out_free, idx_ok, clr_last, issue_last;
  req_t                          req;
  logic [IW-1:0]                 ord_lim, pos_sel, pos_new;
  logic [IW:0]                   pos_inc;
  logic [CNTW-1:0]               cnt_lim, ch_inc;
  logic [CHW-1:0]                ch_sel, ch_next;
  logic [AW-1:0]                 base_nxt;
  mac_ctrl_t                     iss;
  logic                          mac_busy;
  logic signed [SAMPLE_BITS-1:0] mac_y;
  logic                          tap_ff_we, tap_fb_we, tap_clr, tap_re;
  logic [IW-1:0]                 tap_waddr;
  logic [COEF_BITS-1:0]          tap_wdata;
  logic signed [COEF_BITS-1:0]   tap_ff_q, tap_fb_q;
  logic                          hist_we, hist_re;
  logic [AW-1:0]                 hist_waddr, hist_raddr;
  logic [HIST_W-1:0]             hist_wdata, hist_q;

  // Handshakes
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign cfg_acc  = cfg_ch.valid && cfg_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign req      = req_t'(in_ch.req_type);
  assign idx_ok   = {1'b0, in_ch.coeff_index} <= (IW+1)'(MAX_ORDER);

  // Order and channel count limited to what the storage holds
  assign ord_lim = (filter_order_r > IW'(MAX_ORDER)) ? IW'(MAX_ORDER) : filter_order_r;
  assign cnt_lim = (channel_count_r == '0) ? CNTW'(1)
                 : (channel_count_r > CNTW'(CHANNELS)) ? CNTW'(CHANNELS) : channel_count_r;
  assign ch_sel  = (CNTW'(cur_ch_r) >= cnt_lim) ? '0 : cur_ch_r;

  // Ring position of the current channel and its successor
  assign pos_sel  = (hist_pos_r[ch_r] > IW'(MAX_ORDER)) ? '0 : hist_pos_r[ch_r];
  assign pos_inc  = {1'b0, pos_r} + (IW+1)'(1);
  assign pos_new  = (pos_inc > {1'b0, ord_r}) ? '0 : pos_inc[IW-1:0];
  assign base_nxt = AW'(int'(ch_r) * RING);
  assign ch_inc   = CNTW'(ch_r) + CNTW'(1);
  assign ch_next  = (ch_inc >= cnt_lim) ? '0 : ch_inc[CHW-1:0];

  assign clr_last   = clr_cnt_r == AW'(HIST_DEPTH - 1);
  assign issue_last = (i_r == '0) ? (ord_r == '0) : (phase_r && (i_r == ord_r));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && req == REQ_SAMPLE) begin
          state_nxt = ST_SETUP;
        end else if (in_acc && req == REQ_CLEAR) begin
          state_nxt = ST_CLEAR;
        end
      end
      ST_SETUP: begin
        state_nxt = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (issue_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory controls and multiply slots
  always_comb begin
    in_ch.ready = 1'b0;
    iss         = '0;
    tap_clr     = 1'b0;
    tap_ff_we   = 1'b0;
    tap_fb_we   = 1'b0;
    tap_re      = 1'b0;
    hist_we     = 1'b0;
    hist_re     = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        hist_we = 1'b1;
        tap_clr = clr_taps_r && ({1'b0, clr_cnt_r} < (AW+1)'(RING));
        tap_ff_we = tap_clr;
        tap_fb_we = tap_clr;
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        tap_ff_we   = in_acc && req == REQ_FF_COEF && idx_ok;
        tap_fb_we   = in_acc && req == REQ_FB_COEF && idx_ok;
      end
      ST_ISSUE: begin
        iss.vld = 1'b1;
        if (i_r == '0) begin
          iss.sel = MAC_X0;
          tap_re  = 1'b1;
        end else if (!phase_r) begin
          iss.sel = MAC_FF;
          tap_re  = 1'b1;
          hist_re = 1'b1;
        end else begin
          iss.sel = MAC_FB;
        end
      end
      ST_DONE: begin
        hist_we = out_free;
      end
      default: begin
      end
    endcase
  end

  assign tap_waddr  = tap_clr ? clr_cnt_r[IW-1:0] : in_ch.coeff_index;
  assign tap_wdata  = tap_clr ? '0 : in_ch.coeff_value;
  assign hist_raddr = base_r + AW'(j_r);
  assign hist_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : base_r + AW'(pos_new);
  assign hist_wdata = (state_r == ST_CLEAR) ? '0 : {x0_r, mac_y};

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_CLEAR;
      clr_cnt_r       <= '0;
      clr_taps_r      <= 1'b1;
      filter_order_r  <= IW'(4);
      channel_count_r <= CNTW'(1);
      cur_ch_r        <= '0;
      i_r             <= '0;
      phase_r         <= 1'b0;
      out_valid_r     <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        hist_pos_r[c] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      // Register writes
      if (cfg_acc) begin
        unique case (cfg_reg_t'(cfg_ch.index))
          CFG_FILTER_ORDER:  filter_order_r  <= cfg_ch.data[IW-1:0];
          CFG_CHANNEL_COUNT: channel_count_r <= cfg_ch.data[CNTW-1:0];
          default: begin
          end
        endcase
      end

      // Clearing pass
      if (state_r == ST_CLEAR) begin
        if (clr_last) begin
          clr_cnt_r  <= '0;
          clr_taps_r <= 1'b0;
        end else begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
        end
      end

      // Clear item drops positions and the channel counter at once
      if (state_r == ST_IDLE && in_acc && req == REQ_CLEAR) begin
        cur_ch_r <= '0;
        for (int c = 0; c < CHANNELS; c++) begin
          hist_pos_r[c] <= '0;
        end
      end

      // Tap walk: index and phase within the index
      if (state_r == ST_SETUP) begin
        i_r     <= '0;
        phase_r <= 1'b0;
      end else if (state_r == ST_ISSUE) begin
        if (i_r == '0) begin
          i_r     <= IW'(1);
          phase_r <= 1'b0;
        end else if (!phase_r) begin
          phase_r <= 1'b1;
        end else begin
          phase_r <= 1'b0;
          i_r     <= i_r + IW'(1);
        end
      end

      // Write-back: advance ring and channel, present the result
      if (state_r == ST_DONE && out_free) begin
        hist_pos_r[ch_r] <= pos_new;
        cur_ch_r         <= ch_next;
        out_valid_r      <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per-sample working registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc && req == REQ_SAMPLE) begin
      x0_r  <= in_ch.sample_in;
      ch_r  <= ch_sel;
      ord_r <= ord_lim;
    end
    if (state_r == ST_SETUP) begin
      pos_r  <= pos_sel;
      j_r    <= pos_sel;
      base_r <= base_nxt;
    end else if (state_r == ST_ISSUE && i_r != '0 && phase_r) begin
      j_r <= (j_r == '0) ? ord_r : j_r - IW'(1);
    end
    if (state_r == ST_DONE && out_free) begin
      out_sample_r <= mac_y;
      out_chan_r   <= ch_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.sample_out    = out_sample_r;
  assign out_ch.channel_index = out_chan_r;
  assign cfg_ch.ready         = 1'b1;

  mciir_tap_mem #(
    .DEPTH     (RING),
    .AW        (IW),
    .COEF_BITS (COEF_BITS)
  ) u_tap_mem (
    .clk   (clk),
    .ff_we (tap_ff_we),
    .fb_we (tap_fb_we),
    .waddr (tap_waddr),
    .wdata (tap_wdata),
    .re    (tap_re),
    .raddr (i_r),
    .ff_q  (tap_ff_q),
    .fb_q  (tap_fb_q)
  );

  mciir_hist_mem #(
    .DEPTH (HIST_DEPTH),
    .AW    (AW),
    .WIDTH (HIST_W)
  ) u_hist_mem (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .re    (hist_re),
    .raddr (hist_raddr),
    .rdata (hist_q)
  );

  mciir_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS),
    .MAX_ORDER   (MAX_ORDER)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .iss   (iss),
    .x0    (x0_r),
    .ih    (hist_q[HIST_W-1:SAMPLE_BITS]),
    .oh    (hist_q[SAMPLE_BITS-1:0]),
    .ff    (tap_ff_q),
    .fb    (tap_fb_q),
    .busy  (mac_busy),
    .y     (mac_y)
  );

`ifndef SYNTHESIS
  // Accumulator has settled before the result is taken
  a_done_idle_mac: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |-> !mac_busy)
    else $error("result taken while multiply-accumulate still busy");

  // History reads stay inside the memory
  a_hist_addr: assert property (@(posedge clk) disable iff (!rst_n)
    hist_re |-> {1'b0, hist_raddr} < (AW+1)'(HIST_DEPTH))
    else $error("history read address out of range");

  // A result appears only from write-back
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result register loaded outside write-back");

  // Tap walk never passes the order
  a_tap_walk: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ISSUE |-> i_r <= ord_r)
    else $error("tap index beyond filter order");
`endif

endmodule

[test/tb_multichannel_iir_filter.sv]
`timescale 1ns / 100ps

module tb_multichannel_iir_filter;
  import mciir_pkg::*;

  localparam int MAX_ORDER   = 32;
  localparam int CHANNELS    = 8;
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 48;
  localparam int SETTLE      = 340;  // clearing pass plus the longest sample
  localparam int HOLD_CYCLES = 500;

  localparam logic signed [47:0] COEF_ONE  = 48'sh010000000000;
  localparam logic signed [47:0] COEF_HALF = 48'sh008000000000;
  localparam logic signed [47:0] COEF_MAX  = 48'sh7FFFFFFFFFFF;
  localparam logic signed [47:0] COEF_MIN  = 48'sh800000000000;
  localparam logic signed [23:0] SMP_MAX   = 24'sh7FFFFF;
  localparam logic signed [23:0] SMP_MIN   = 24'sh800000;

  typedef struct {
    req_t               kind;
    logic signed [23:0] smp;
    logic [5:0]         idx;
    logic signed [47:0] coef;
  } request_t;

  typedef struct {
    logic signed [23:0] value;
    logic [2:0]         chan;
  } filtered_t;

  logic clk = 1'b0;
  logic rst_n;

  mciir_in_if #(.SAMPLE_BITS(SAMPLE_BITS), .COEF_BITS(COEF_BITS), .IDX_BITS(6)) in_ch ();
  mciir_out_if #(.SAMPLE_BITS(SAMPLE_BITS), .CH_BITS(3)) out_ch ();
  mciir_cfg_if #(.DATA_BITS(6)) cfg_ch ();

  multichannel_iir_filter #(
    .MAX_ORDER  (MAX_ORDER),
    .CHANNELS   (CHANNELS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEF_BITS  (COEF_BITS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #10 clk = ~clk;

  // Stimulus and expectation stores
  request_t  request_q [$];
  filtered_t filtered_q [$];
  request_t  offered;
  filtered_t got_want;
  int        mismatches = 0;
  int        send_idle_pct = 0;
  int        out_stall_pct = 0;
  logic      hold_go = 1'b0;
  logic      hold_out;

  // Filter state as the block should hold it
  logic signed [47:0] ff_coef [0:MAX_ORDER];
  logic signed [47:0] fb_coef [0:MAX_ORDER];
  logic signed [23:0] x_past [0:CHANNELS-1][0:MAX_ORDER];
  logic signed [23:0] y_past [0:CHANNELS-1][0:MAX_ORDER];
  int                 ring_ptr [0:CHANNELS-1];
  int                 chan_next;
  logic [5:0]         order_reg;
  logic [3:0]         chans_reg;

  task automatic report_mismatch(string what);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic wipe_history();
    foreach (x_past[c, k]) begin
      x_past[c][k] = '0;
      y_past[c][k] = '0;
    end
    foreach (ring_ptr[c]) ring_ptr[c] = 0;
    chan_next = 0;
  endtask

  // Apply one accepted request; a sample queues the filtered value it yields
  task automatic run_iir_request(request_t r);
    int                  ord;
    int                  cnt;
    int                  ch;
    int                  pos;
    int                  j;
    logic signed [127:0] acc;
    logic signed [127:0] scaled;
    logic signed [23:0]  y;
    case (r.kind)
      REQ_FF_COEF: if (r.idx <= MAX_ORDER) ff_coef[r.idx] = r.coef;
      REQ_FB_COEF: if (r.idx <= MAX_ORDER) fb_coef[r.idx] = r.coef;
      REQ_CLEAR:   wipe_history();
      default: begin
        ord = (order_reg > MAX_ORDER) ? MAX_ORDER : int'(order_reg);
        cnt = (chans_reg == 0) ? 1 : int'(chans_reg);
        if (cnt > CHANNELS) cnt = CHANNELS;
        ch = (chan_next >= cnt) ? 0 : chan_next;
        pos = ring_ptr[ch];
        if (pos > MAX_ORDER) pos = 0;

        // feed-forward then feedback, both walking the ring backward
        acc = ff_coef[0] * r.smp;
        j = pos;
        for (int k = 1; k <= ord; k++) begin
          acc = acc + ff_coef[k] * x_past[ch][j];
          j = (j == 0) ? ord : j - 1;
        end
        j = pos;
        for (int k = 1; k <= ord; k++) begin
          acc = acc + fb_coef[k] * y_past[ch][j];
          j = (j == 0) ? ord : j - 1;
        end

        // round half up to Q1.23, then saturate
        scaled = (acc + (128'sd1 <<< 39)) >>> 40;
        if (scaled > 128'sd8388607) y = SMP_MAX;
        else if (scaled < -128'sd8388608) y = SMP_MIN;
        else y = scaled[23:0];

        pos = (pos + 1 > ord) ? 0 : pos + 1;
        ring_ptr[ch] = pos;
        x_past[ch][pos] = r.smp;
        y_past[ch][pos] = y;
        filtered_q.push_back('{value: y, chan: 3'(ch)});
        chan_next = (ch + 1 >= cnt) ? 0 : ch + 1;
      end
    endcase
  endtask

  task automatic push_item(req_t kind, logic signed [23:0] smp, logic [5:0] idx,
                           logic signed [47:0] coef);
    request_q.push_back('{kind: kind, smp: smp, idx: idx, coef: coef});
  endtask

  function automatic logic signed [23:0] pick_sample();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(19))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return '0;
      3:       return '1;
      4, 5, 6: return {{12{raw[11]}}, raw[11:0]};
      default: return raw[23:0];
    endcase
  endfunction

  // Mostly modest gains so outputs stay in range; some full-scale taps
  function automatic logic signed [47:0] pick_coef();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1:       return raw[47:0];
      2, 3, 4, 5: return {{9{raw[38]}}, raw[38:0]};
      default:    return {{12{raw[35]}}, raw[35:0]};
    endcase
  endfunction

  // Block must be quiet before a register write
  task automatic wait_idle();
    while (request_q.size() != 0 || in_ch.valid || filtered_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t which, logic [5:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= which;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (which == CFG_FILTER_ORDER) order_reg = value;
    else chans_reg = value[3:0];
  endtask

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) run_iir_request(offered);
      if (!in_ch.valid || in_ch.ready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = request_q.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.req_type    <= offered.kind;
          in_ch.sample_in   <= offered.smp;
          in_ch.coeff_index <= offered.idx;
          in_ch.coeff_value <= offered.coef;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (filtered_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d on channel %0d",
                                    out_ch.sample_out, out_ch.channel_index));
        end else begin
          got_want = filtered_q.pop_front();
          if (out_ch.sample_out !== got_want.value)
            report_mismatch($sformatf("sample_out %0d, expected %0d",
                                      out_ch.sample_out, got_want.value));
          if (out_ch.channel_index !== got_want.chan)
            report_mismatch($sformatf("channel_index %0d, expected %0d",
                                      out_ch.channel_index, got_want.chan));
        end
      end
      out_ch.ready <= !hold_out && ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input
  initial begin
    hold_out = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_out <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_out <= 1'b0;
  end

  // Stimulus sequence
  initial begin
    int   phase_order [6] = '{2, 8, 32, 0, 1, 5};
    int   phase_chans [6] = '{3, 8, 15, 0, 1, 6};
    int   phase_idle  [6] = '{0, 68, 0, 30, 68, 0};
    int   phase_stall [6] = '{0, 0, 68, 30, 0, 68};
    int   roll;
    logic [5:0] tap;

    in_ch.valid       = 1'b0;
    in_ch.req_type    = REQ_SAMPLE;
    in_ch.sample_in   = '0;
    in_ch.coeff_index = '0;
    in_ch.coeff_value = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_FILTER_ORDER;
    cfg_ch.data       = '0;
    rst_n             = 1'b0;

    order_reg = 6'd4;
    chans_reg = 4'd1;
    foreach (ff_coef[k]) begin
      ff_coef[k] = '0;
      fb_coef[k] = '0;
    end
    wipe_history();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // reset setting: unity pass, full-scale samples
    @(negedge clk);
    push_item(REQ_FF_COEF, '0, 6'd0, COEF_ONE);
    push_item(REQ_SAMPLE, SMP_MAX, '0, '0);
    push_item(REQ_SAMPLE, SMP_MIN, '0, '0);
    // tap indexes past the end are dropped; feedback tap 0 has no effect
    push_item(REQ_FF_COEF, '0, 6'd33, COEF_MAX);
    push_item(REQ_FB_COEF, '0, 6'd63, COEF_MIN);
    push_item(REQ_FB_COEF, '0, 6'd0, COEF_MAX);
    push_item(REQ_SAMPLE, 24'sd12345, '0, '0);
    // extreme taps at the far end of the ring
    push_item(REQ_FF_COEF, '0, 6'd4, COEF_MIN);
    push_item(REQ_FB_COEF, '0, 6'd4, COEF_HALF);
    push_item(REQ_SAMPLE, 24'sd1000, '0, '0);
    // saturation in both directions
    push_item(REQ_FF_COEF, '0, 6'd0, COEF_MAX);
    push_item(REQ_SAMPLE, SMP_MAX, '0, '0);
    push_item(REQ_SAMPLE, SMP_MIN, '0, '0);
    push_item(REQ_CLEAR, '0, '0, '0);
    push_item(REQ_SAMPLE, 24'sd100, '0, '0);
    wait_idle();

    // order above the maximum, channel count zero
    write_reg(CFG_FILTER_ORDER, 6'd63);
    write_reg(CFG_CHANNEL_COUNT, 6'd0);
    @(negedge clk);
    push_item(REQ_FF_COEF, '0, 6'd0, COEF_ONE);
    push_item(REQ_FF_COEF, '0, 6'd1, COEF_HALF);
    repeat (3) push_item(REQ_SAMPLE, pick_sample(), '0, '0);
    wait_idle();

    // shrink the order below the ring position; channel count above the maximum
    write_reg(CFG_FILTER_ORDER, 6'd2);
    write_reg(CFG_CHANNEL_COUNT, 6'd15);
    @(negedge clk);
    repeat (5) push_item(REQ_SAMPLE, pick_sample(), '0, '0);
    wait_idle();

    // channel counter past the new count falls back to channel zero
    write_reg(CFG_CHANNEL_COUNT, 6'd2);
    @(negedge clk);
    push_item(REQ_SAMPLE, pick_sample(), '0, '0);
    wait_idle();

    // order zero: mute, then pass
    write_reg(CFG_FILTER_ORDER, 6'd0);
    write_reg(CFG_CHANNEL_COUNT, 6'd1);
    @(negedge clk);
    push_item(REQ_FF_COEF, '0, 6'd0, '0);
    push_item(REQ_SAMPLE, SMP_MAX, '0, '0);
    push_item(REQ_FF_COEF, '0, 6'd0, COEF_ONE);
    push_item(REQ_SAMPLE, SMP_MIN, '0, '0);
    wait_idle();

    // random phases, each with its own setting and idling pattern
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_FILTER_ORDER, 6'(phase_order[p]));
      write_reg(CFG_CHANNEL_COUNT, 6'(phase_chans[p]));
      @(negedge clk);
      send_idle_pct = phase_idle[p];
      out_stall_pct = phase_stall[p];
      if (p == 0) hold_go = 1'b1;
      repeat (100) begin
        roll = $urandom_range(99);
        tap = ($urandom_range(6) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(32));
        if (roll < 80) push_item(REQ_SAMPLE, pick_sample(), 6'($urandom), pick_coef());
        else if (roll < 89) push_item(REQ_FF_COEF, pick_sample(), tap, pick_coef());
        else if (roll < 98) push_item(REQ_FB_COEF, pick_sample(), tap, pick_coef());
        else push_item(REQ_CLEAR, pick_sample(), tap, pick_coef());
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("tb_multichannel_iir_filter: PASS");
    end else begin
      $display("tb_multichannel_iir_filter: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("tb_multichannel_iir_filter: FAIL");
    $finish;
  end

endmodule
